/* rtl/ddo_pkg.sv */
// Shared types, constants and the sine table for the wheel odometry block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package ddo_pkg;

    // Field widths
    localparam int DELTA_W = 16;
    localparam int GAIN_W  = 20;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 16;
    localparam int SINE_W  = 16;

    // Sine table geometry
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SCALED_W         = HEAD_W + SINE_IDX_W;

    // Datapath widths: |distance| stays below 2^20, so 21 bits signed hold it
    localparam int DIST_W     = 21;
    localparam int SUM_W      = DELTA_W + 1;
    localparam int MUL_A_W    = DIST_W;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int DIST_SHIFT = 16;
    localparam int TRIG_SHIFT = 15;

    localparam logic [HEAD_W-1:0] QUARTER_TURN = HEAD_W'(16384);

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = CFG_IDX_W'(1);
    localparam logic [GAIN_W-1:0]    DISTANCE_GAIN_RST = GAIN_W'(10748);
    localparam logic [GAIN_W-1:0]    HEADING_GAIN_RST  = GAIN_W'(60018);

    typedef struct packed {
        logic signed [DELTA_W-1:0] left_delta;
        logic signed [DELTA_W-1:0] right_delta;
    } wheel_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pose_x;
        logic signed [POS_W-1:0] pose_y;
        logic [HEAD_W-1:0]       pose_heading;
    } pose_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef logic signed [SINE_W-1:0] sine_lut_t [SINE_TABLE_DEPTH];

    // Polynomial sine of a binary angle, Q1.15 result
    function automatic logic signed [SINE_W-1:0] poly_sine(longint angle);
        longint t;
        longint x;
        longint x2;
        longint p;
        longint r;
        t = angle & 64'hFFFF;
        if (t >= 32768)
            t = t - 65536;
        if (t > 16384)
            t = 32768 - t;
        else if (t < -16384)
            t = -32768 - t;
        x  = t * 2;
        x2 = (x * x) >>> 15;
        p  = 51472 - ((x2 * (21024 - ((x2 * 2320) >>> 15))) >>> 15);
        r  = (x * p) >>> 15;
        if (r > 32767)
            r = 32767;
        if (r < -32767)
            r = -32767;
        return SINE_W'(r);
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t lut;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
        begin
            lut[k] = poly_sine((longint'(k) * 65536) / SINE_TABLE_DEPTH);
        end
        return lut;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

`default_nettype wire

/* rtl/ddo_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on ddo_pkg for widths and the request struct.
`default_nettype none

module ddo_mul (
    input  wire logic                                clk,
    input  wire ddo_pkg::mul_req_t                   req,
    output logic signed [ddo_pkg::MUL_P_W-1:0]       prod
);

    logic signed [ddo_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [ddo_pkg::MUL_P_W-1:0] prod_next;

    // Both operands are signed, so the product sign-extends them
    assign prod_next = req.a * req.b;

    // Hold the product unless a new pass is requested
    always_ff @(posedge clk)
    begin
        if (req.en)
            prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* rtl/ddo_sine_rom.sv */
// Sine and cosine lookup of the current heading, registered outputs.
// Depends on ddo_pkg for the constant table and widths.
`default_nettype none

module ddo_sine_rom (
    input  wire logic                               clk,
    input  wire logic [ddo_pkg::HEAD_W-1:0]         heading,
    output logic signed [ddo_pkg::SINE_W-1:0]       sin_val,
    output logic signed [ddo_pkg::SINE_W-1:0]       cos_val
);

    logic [ddo_pkg::HEAD_W-1:0]         cos_angle;
    logic [ddo_pkg::SCALED_W-1:0]       sin_scaled;
    logic [ddo_pkg::SCALED_W-1:0]       cos_scaled;
    logic [ddo_pkg::SINE_IDX_W-1:0]     sin_idx;
    logic [ddo_pkg::SINE_IDX_W-1:0]     cos_idx;
    logic signed [ddo_pkg::SINE_W-1:0]  sin_reg;
    logic signed [ddo_pkg::SINE_W-1:0]  cos_reg;

    // Cosine is the sine a quarter turn on, wrapping
    assign cos_angle = heading + ddo_pkg::QUARTER_TURN;

    // Scale the angle to a table index: floor(angle * depth / 2^16)
    assign sin_scaled = ddo_pkg::SCALED_W'(heading)
                        * ddo_pkg::SCALED_W'(ddo_pkg::SINE_TABLE_DEPTH);
    assign cos_scaled = ddo_pkg::SCALED_W'(cos_angle)
                        * ddo_pkg::SCALED_W'(ddo_pkg::SINE_TABLE_DEPTH);
    assign sin_idx = sin_scaled[ddo_pkg::HEAD_W +: ddo_pkg::SINE_IDX_W];
    assign cos_idx = cos_scaled[ddo_pkg::HEAD_W +: ddo_pkg::SINE_IDX_W];

    // Register the table words
    always_ff @(posedge clk)
    begin
        sin_reg <= ddo_pkg::SINE_LUT[sin_idx];
        cos_reg <= ddo_pkg::SINE_LUT[cos_idx];
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

/* rtl/differential_drive_odometry_top.sv */
// Top level of the wheel odometry block: sequencer, pose state and ports.
// Depends on ddo_pkg, ddo_mul and ddo_sine_rom.
//
//  channel | direction | handshake                | word
//  wheel   | in        | wheel_valid/wheel_ready  | ddo_pkg::wheel_t
//  pose    | out       | pose_valid/pose_ready    | ddo_pkg::pose_t
//  cfg     | in        | cfg_valid/cfg_ready      | cfg_index, cfg_data
//
// After acceptance, one wheel word makes four passes through the one shared
// multiplier, then write-back. A new wheel word is taken only in idle, so
// the sequencer does not take the next one until write-back of the last is done.
// The pose word sits in an output register; a finished word waits there
// while the next wheel word is already being worked on, and write-back
// stalls only if the previous pose word has not yet been taken.
// Reset clears the pose to zero and restores the gains; cfg is always ready.
`default_nettype none

module differential_drive_odometry_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wheel_valid,
    output logic                                    wheel_ready,
    input  wire ddo_pkg::wheel_t                    wheel,
    output logic                                    pose_valid,
    input  wire logic                               pose_ready,
    output ddo_pkg::pose_t                          pose,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ddo_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_STEP,
        S_PX,
        S_PY,
        S_HEAD
    } state_t;

    state_t                                 state_reg;
    ddo_pkg::wheel_t                        wheel_reg;
    logic [ddo_pkg::GAIN_W-1:0]             dist_gain_reg;
    logic [ddo_pkg::GAIN_W-1:0]             head_gain_reg;
    logic signed [ddo_pkg::DIST_W-1:0]      dist_reg;
    logic [ddo_pkg::HEAD_W-1:0]             step_reg;
    logic signed [ddo_pkg::POS_W-1:0]       x_reg;
    logic signed [ddo_pkg::POS_W-1:0]       y_reg;
    logic [ddo_pkg::HEAD_W-1:0]             head_reg;
    logic                                   pose_valid_reg;
    ddo_pkg::pose_t                         pose_reg;

    logic signed [ddo_pkg::SUM_W-1:0]       wheel_sum;
    logic signed [ddo_pkg::SUM_W-1:0]       wheel_diff;
    logic signed [ddo_pkg::MUL_P_W-1:0]     prod;
    logic signed [ddo_pkg::SINE_W-1:0]      sin_val;
    logic signed [ddo_pkg::SINE_W-1:0]      cos_val;
    logic signed [ddo_pkg::DIST_W-1:0]      trig_part;
    logic signed [ddo_pkg::POS_W-1:0]       pos_next;
    logic [ddo_pkg::HEAD_W-1:0]             head_next;
    logic                                   slot_free;
    ddo_pkg::mul_req_t                      mul_req;

    // Add with clamp to the signed position range
    function automatic logic signed [ddo_pkg::POS_W-1:0] sat_add(
        logic signed [ddo_pkg::POS_W-1:0]  base,
        logic signed [ddo_pkg::DIST_W-1:0] delta
    );
        logic signed [ddo_pkg::POS_W:0] wide;
        wide = (ddo_pkg::POS_W+1)'(base) + (ddo_pkg::POS_W+1)'(delta);
        if (wide[ddo_pkg::POS_W] != wide[ddo_pkg::POS_W-1])
            return {wide[ddo_pkg::POS_W], {(ddo_pkg::POS_W-1){~wide[ddo_pkg::POS_W]}}};
        return wide[ddo_pkg::POS_W-1:0];
    endfunction

    // Wheel sum and difference, one bit wider than the deltas
    assign wheel_sum  = ddo_pkg::SUM_W'(wheel_reg.right_delta)
                        + ddo_pkg::SUM_W'(wheel_reg.left_delta);
    assign wheel_diff = ddo_pkg::SUM_W'(wheel_reg.right_delta)
                        - ddo_pkg::SUM_W'(wheel_reg.left_delta);

    // Select operands of the shared multiplier per step
    always_comb
    begin
        mul_req = '0;
        case (state_reg)
            S_DIST:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = ddo_pkg::MUL_A_W'(wheel_sum);
                mul_req.b  = signed'({1'b0, dist_gain_reg});
            end
            S_STEP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = ddo_pkg::MUL_A_W'(wheel_diff);
                mul_req.b  = signed'({1'b0, head_gain_reg});
            end
            S_PX:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = dist_reg;
                mul_req.b  = ddo_pkg::MUL_B_W'(cos_val);
            end
            S_PY:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = dist_reg;
                mul_req.b  = ddo_pkg::MUL_B_W'(sin_val);
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    ddo_sine_rom u_rom (
        .clk     (clk),
        .heading (head_reg),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // Scaled trig product, floor by 2^15; the cosine product lands in S_PY,
    // the sine product in S_HEAD
    assign trig_part = prod[ddo_pkg::TRIG_SHIFT +: ddo_pkg::DIST_W];
    assign pos_next  = (state_reg == S_PY) ? sat_add(x_reg, trig_part)
                                           : sat_add(y_reg, trig_part);
    assign head_next = head_reg + step_reg;
    assign slot_free = !pose_valid_reg || pose_ready;

    // Sequencer, pose state, gains and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dist_gain_reg  <= ddo_pkg::DISTANCE_GAIN_RST;
            head_gain_reg  <= ddo_pkg::HEADING_GAIN_RST;
            x_reg          <= '0;
            y_reg          <= '0;
            head_reg       <= '0;
            pose_valid_reg <= 1'b0;
            pose_reg       <= '0;
        end
        else
        begin
            // Drop the pose word once taken, unless a new one is written back now
            if (pose_valid_reg && pose_ready && !(state_reg == S_HEAD && slot_free))
                pose_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_index)
                    ddo_pkg::REG_DISTANCE_GAIN: dist_gain_reg <= cfg_data[ddo_pkg::GAIN_W-1:0];
                    ddo_pkg::REG_HEADING_GAIN:  head_gain_reg <= cfg_data[ddo_pkg::GAIN_W-1:0];
                    default:                    ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (wheel_valid)
                        state_reg <= S_DIST;
                end
                S_DIST:
                begin
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    state_reg <= S_PX;
                end
                S_PX:
                begin
                    state_reg <= S_PY;
                end
                S_PY:
                begin
                    x_reg     <= pos_next;
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    // Write back only when the output register can take the word
                    if (slot_free)
                    begin
                        y_reg                 <= pos_next;
                        head_reg              <= head_next;
                        pose_reg.pose_x       <= x_reg;
                        pose_reg.pose_y       <= pos_next;
                        pose_reg.pose_heading <= head_next;
                        pose_valid_reg        <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Capture the wheel word and intermediate products
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && wheel_valid)
            wheel_reg <= wheel;
        if (state_reg == S_STEP)
            dist_reg <= prod[ddo_pkg::DIST_SHIFT +: ddo_pkg::DIST_W];
        if (state_reg == S_PX)
            step_reg <= prod[ddo_pkg::DIST_SHIFT +: ddo_pkg::HEAD_W];
    end

    assign wheel_ready = (state_reg == S_IDLE);
    assign pose_valid  = pose_valid_reg;
    assign pose        = pose_reg;
    assign cfg_ready   = 1'b1;

endmodule

`default_nettype wire

/* rtl/ddo_checker.sv */
// Port-level checks for the wheel odometry top level, bound to it below.
// Depends on ddo_pkg for the port types.
`default_nettype none

module ddo_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            wheel_valid,
    input wire logic                            wheel_ready,
    input wire logic                            pose_valid,
    input wire logic                            pose_ready,
    input wire ddo_pkg::pose_t                  pose,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready
);

    // A stalled pose word holds
    a_pose_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_ready |=> pose_valid && $stable(pose))
        else $error("pose word changed or dropped while stalled");

    // Busy in the cycle after taking a wheel word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        wheel_valid && wheel_ready |=> !wheel_ready)
        else $error("wheel word accepted in back-to-back cycles");

    // A new pose word only appears at the end of work, never from idle
    a_pose_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pose_valid) |-> !$past(wheel_ready))
        else $error("pose word appeared while the block was idle");

    // The configuration port never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind differential_drive_odometry_top ddo_checker u_ddo_checker (.*);

`default_nettype wire
